>>> src/vda_pkg.sv
// Package for the variable bit-length delta audio decoder.
// Holds the item structs, the queue entry type and the shared constants.
// Depends on nothing; every module of the decoder imports it.
package vda_pkg;

	localparam int MAX_SAMPLES       = 4096;
	localparam int SHORT_SILENCE_RUN = 4;
	localparam int LONG_SILENCE_RUN  = 16;

	localparam int COUNT_W   = 13;
	localparam int SILENCE_W = 5;
	localparam int STORE_W   = 15;
	localparam int FILL_W    = 4;
	localparam int CODE_W    = 3;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic       KIND_HEADER        = 1'b0;
	localparam logic       KIND_DATA          = 1'b1;
	localparam logic [2:0] CODE_SHORT_SILENCE = 3'd0;
	localparam logic [2:0] CODE_LONG_SILENCE  = 3'd1;

	typedef struct packed {
		logic                      kind;
		logic [7:0]                data_byte;
		logic [7:0]                header_scale;
		logic signed [7:0]         first_sample;
		logic [COUNT_W-1:0]        packet_samples;
	} in_item_t;

	typedef struct packed {
		logic signed [7:0] sample;
		logic [7:0]        scale;
		logic              last;
	} out_item_t;

	// Classified entry between the front and the back: the byte is the data
	// byte for a data item and the first sample for a header.
	typedef struct packed {
		logic               is_header;
		logic [7:0]         value;
		logic [7:0]         scale;
		logic [COUNT_W-1:0] total;
	} q_entry_t;

endpackage

>>> src/vbr_delta_audio_decoder_core.sv
// Variable bit-length delta PCM decoder for 8-bit audio packets: a header item
// emits the first sample, and each data byte is then loaded into the bit store
// and decoded step by step (a step is a code read, a delta, a run terminator or
// a silence sample), with one more step once the buffered bits run out. The
// symbol engine in the back end does this work; a four-entry queue behind a
// front register lets the input keep taking items while the engine works or
// the output stalls, and results leave through one output register.
// Depends on vda_pkg, vda_front, vda_queue and vda_back.
module vbr_delta_audio_decoder_core import vda_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic     push_valid;
	logic     push_ready;
	q_entry_t push_entry;
	logic     pop_valid;
	logic     pop;
	q_entry_t pop_entry;

	vda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	vda_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_entry  (pop_entry)
	);

	vda_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (pop_valid),
		.q_pop        (pop),
		.q_entry      (pop_entry),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

>>> src/vda_front.sv
// Front end of the decoder: accepts input items, classifies them and clamps
// the packet count. Holds one classified entry until the queue takes it.
// Depends on vda_pkg.
module vda_front import vda_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      push_valid,
	input  logic      push_ready,
	output q_entry_t  push_entry
);

	logic     hold_valid_q;
	q_entry_t hold_q;
	q_entry_t entry_d;
	logic     take;

	assign item_ready = !hold_valid_q || push_ready;
	assign take       = item_valid && item_ready;
	assign push_valid = hold_valid_q;
	assign push_entry = hold_q;

	always_comb begin
		entry_d.is_header = (item.kind == KIND_HEADER);
		entry_d.scale     = item.header_scale;
		entry_d.value     = (item.kind == KIND_HEADER) ? item.first_sample : item.data_byte;
		// A zero count still yields the first sample; large counts saturate.
		if (item.packet_samples == '0) begin
			entry_d.total = COUNT_W'(1);
		end else if (item.packet_samples > COUNT_W'(MAX_SAMPLES)) begin
			entry_d.total = COUNT_W'(MAX_SAMPLES);
		end else begin
			entry_d.total = item.packet_samples;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (take) begin
			hold_valid_q <= 1'b1;
		end else if (push_ready) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hold_q <= entry_d;
		end
	end

endmodule

>>> src/vda_queue.sv
// Short queue of classified entries between the front and the back end.
// Register based, one write and one read position per cycle.
// Depends on vda_pkg.
module vda_queue import vda_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  q_entry_t push_entry,
	output logic     pop_valid,
	input  logic     pop,
	output q_entry_t pop_entry
);

	q_entry_t            slots_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

>>> src/vda_back.sv
// Back end: the symbol engine and the result register. Takes one queue
// entry at a time; one decode step per cycle unless the output stalls.
// Depends on vda_pkg.
module vda_back import vda_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_pop,
	input  q_entry_t  q_entry,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic                 busy_q, busy_d;
	logic [STORE_W-1:0]   store_q, store_d;
	logic [FILL_W-1:0]    fill_q, fill_d;
	logic                 mode_q, mode_d;
	logic [3:0]           width_q, width_d;
	logic [SILENCE_W-1:0] silence_q, silence_d;
	logic [7:0]           acc_q, acc_d;
	logic [COUNT_W-1:0]   left_q, left_d;
	logic [7:0]           scale_q, scale_d;
	logic                 res_valid_q;
	out_item_t            res_q;

	logic                 out_free;
	logic                 emit;
	logic [7:0]           mask8;
	logic [7:0]           sign_bit;
	logic [7:0]           delta_raw;
	logic [7:0]           delta_ext;
	logic [CODE_W-1:0]    code;
	logic [COUNT_W-1:0]   left_after;

	assign out_free     = !res_valid_q || result_ready;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_comb begin
		mask8     = 8'((9'd1 << width_q) - 9'd1);
		sign_bit  = 8'(9'd1 << (width_q - 4'd1));
		delta_raw = store_q[7:0] & mask8;
		delta_ext = ((delta_raw & sign_bit) != '0) ? (delta_raw | ~mask8) : delta_raw;
		code      = store_q[CODE_W-1:0];
	end

	always_comb begin
		busy_d     = busy_q;
		store_d    = store_q;
		fill_d     = fill_q;
		mode_d     = mode_q;
		width_d    = width_q;
		silence_d  = silence_q;
		acc_d      = acc_q;
		left_d     = left_q;
		scale_d    = scale_q;
		emit       = 1'b0;
		q_pop      = 1'b0;
		left_after = left_q;

		if (busy_q) begin
			if (left_q == '0) begin
				busy_d = 1'b0;
			end else if (silence_q != '0) begin
				if (out_free) begin
					silence_d = silence_q - SILENCE_W'(1);
					emit      = 1'b1;
				end
			end else if (mode_q) begin
				if (fill_q < width_q) begin
					busy_d = 1'b0;
				end else if (delta_raw == sign_bit) begin
					// The most negative value of the width closes the run.
					store_d = store_q >> width_q;
					fill_d  = fill_q - width_q;
					mode_d  = 1'b0;
				end else if (out_free) begin
					store_d = store_q >> width_q;
					fill_d  = fill_q - width_q;
					acc_d   = acc_q + delta_ext;
					emit    = 1'b1;
				end
			end else begin
				if (fill_q < FILL_W'(CODE_W)) begin
					busy_d = 1'b0;
				end else begin
					store_d = store_q >> CODE_W;
					fill_d  = fill_q - FILL_W'(CODE_W);
					if (code == CODE_SHORT_SILENCE) begin
						acc_d     = '0;
						silence_d = SILENCE_W'(SHORT_SILENCE_RUN);
					end else if (code == CODE_LONG_SILENCE) begin
						acc_d     = '0;
						silence_d = SILENCE_W'(LONG_SILENCE_RUN);
					end else begin
						width_d = 4'({1'b0, code} + 4'd1);
						mode_d  = 1'b1;
					end
				end
			end
		end else if (q_valid && out_free) begin
			q_pop = 1'b1;
			if (q_entry.is_header) begin
				scale_d   = q_entry.scale;
				acc_d     = q_entry.value;
				store_d   = '0;
				fill_d    = '0;
				mode_d    = 1'b0;
				width_d   = '0;
				silence_d = '0;
				left_d    = q_entry.total;
				emit      = 1'b1;
			end else if (left_q != '0) begin
				store_d = store_q | STORE_W'({7'd0, q_entry.value} << fill_q);
				fill_d  = fill_q + FILL_W'(8);
				busy_d  = 1'b1;
			end
		end

		if (emit) begin
			left_after = left_d - COUNT_W'(1);
			left_d     = left_after;
			// The final sample ends the packet and drops any leftover bits.
			if (left_after == '0) begin
				store_d   = '0;
				fill_d    = '0;
				silence_d = '0;
				mode_d    = 1'b0;
				busy_d    = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			store_q     <= '0;
			fill_q      <= '0;
			mode_q      <= 1'b0;
			width_q     <= '0;
			silence_q   <= '0;
			acc_q       <= '0;
			left_q      <= '0;
			scale_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			busy_q    <= busy_d;
			store_q   <= store_d;
			fill_q    <= fill_d;
			mode_q    <= mode_d;
			width_q   <= width_d;
			silence_q <= silence_d;
			acc_q     <= acc_d;
			left_q    <= left_d;
			scale_q   <= scale_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.sample <= acc_d;
			res_q.scale  <= scale_d;
			res_q.last   <= (left_after == '0);
		end
	end

endmodule
